FILE: rtl/gtcd_pkg.sv
// Shared types, constants and helper functions of the gap tail CUSUM detector.
package gtcd_pkg;

   localparam int DEF_WINDOW_DEPTH  = 128;
   localparam int DEF_UPDATE_STRIDE = 32;

   localparam int GAP_W   = 32;
   localparam int REG_W   = 21;
   localparam int IDX_REG_W = 3;
   localparam int DIV_W   = 48;
   localparam int DIV_CNT_W = 6;

   localparam logic [31:0] Q_ONE        = 32'd65536;
   localparam logic [31:0] ABS_GUARD_US = 32'd5000;

   typedef enum logic [IDX_REG_W-1:0] {
      REG_ON_DELTA   = 3'd0,
      REG_ON_THR     = 3'd1,
      REG_ON_CAP     = 3'd2,
      REG_CLEAR_THR  = 3'd3,
      REG_OFF_THR    = 3'd4,
      REG_OFF_CAP    = 3'd5,
      REG_BASE_MIN   = 3'd6,
      REG_BASE_MAX   = 3'd7
   } csr_index_type;

   localparam logic [REG_W-1:0] RST_ON_DELTA  = 21'd32768;
   localparam logic [REG_W-1:0] RST_ON_THR    = 21'd196608;
   localparam logic [REG_W-1:0] RST_ON_CAP    = 21'd131072;
   localparam logic [REG_W-1:0] RST_CLEAR_THR = 21'd32768;
   localparam logic [REG_W-1:0] RST_OFF_THR   = 21'd196608;
   localparam logic [REG_W-1:0] RST_OFF_CAP   = 21'd32768;
   localparam logic [REG_W-1:0] RST_BASE_MIN  = 21'd78643;
   localparam logic [REG_W-1:0] RST_BASE_MAX  = 21'd163840;

   typedef enum logic [1:0] {
      PATH_UNKNOWN  = 2'd0,
      PATH_REGULAR  = 2'd1,
      PATH_DEGRADED = 2'd2
   } path_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SELECT,
      S_DIV_RATIO,
      S_DIV_EXCESS,
      S_UPDATE,
      S_DONE
   } state_type;

   // Sorted-window index of a percentile: ceil(pct*(depth-1)/100), clamped.
   function automatic int rank_idx(input int pct, input int depth);
      int idx;
      idx = (pct * (depth - 1) + 99) / 100;
      if (idx >= depth) idx = depth - 1;
      return idx;
   endfunction

endpackage

FILE: rtl/gtcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gtcd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/gap_tail_cusum_detector.sv
// Top level of the gap tail CUSUM detector: window store, quantile select and CUSUM update.
//
// Usage. Each req_ transfer carries one inter-frame gap in microseconds. A zero gap
// is ignored and reported with the current values. Nonzero gaps are written into a
// ring of WINDOW_DEPTH entries. Once the ring is full, the median and the 95th
// percentile are found and the tail ratio drives two clipped CUSUMs that move the
// path between regular and degraded. Statistics are recomputed on the first full
// window and then on every UPDATE_STRIDE-th nonzero gap.
// Every accepted item yields exactly one rsp_ transfer.
// An item without recompute goes from idle to the done state and is loaded into the output
// register once it is free; the next req_ transfer is taken once the block is back in idle.
// A recompute runs a bitwise radix select over the window: for each of the 32 bit
// positions it reads every entry, one RAM read per cycle, and then settles the bit.
// Two divisions on one shared restoring divider and an update step follow; the
// calibrating window skips the second division and the update.
// req_tready is low while an item is in work. A finished result sits in the output
// register; if the receiver stalls, the next item may still be accepted and worked
// on, and it waits at its end until the output register frees.
// Reset (synchronous, active high) clears all statistics, the CUSUMs and the path state to
// unknown and loads the register defaults; the window needs no clearing. The csr_ port
// writes one register per cycle and must be used only while idle; the block does not check.
module gap_tail_cusum_detector #(
   parameter int WINDOW_DEPTH  = gtcd_pkg::DEF_WINDOW_DEPTH,
   parameter int UPDATE_STRIDE = gtcd_pkg::DEF_UPDATE_STRIDE
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,  // [31:0] gap_us
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [175:0]                   rsp_tdata,  // median_gap, tail_gap, p95_ratio,
                                                      // p95_excess, on_sum, off_sum, zero pad
   output logic [2:0]                     rsp_tuser,  // [1:0] path_state, [2] stats_updated
   input  logic                           csr_wr_en,
   input  logic [gtcd_pkg::IDX_REG_W-1:0] csr_index,
   input  logic [gtcd_pkg::REG_W-1:0]     csr_wdata
);

   localparam int IDX_W  = $clog2(WINDOW_DEPTH);
   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int STR_W  = $clog2(UPDATE_STRIDE + 1);
   localparam int RANK50 = gtcd_pkg::rank_idx(50, WINDOW_DEPTH);
   localparam int RANK95 = gtcd_pkg::rank_idx(95, WINDOW_DEPTH);
   localparam int RW     = gtcd_pkg::REG_W;
   localparam int DW     = gtcd_pkg::DIV_W;
   localparam int DCW    = gtcd_pkg::DIV_CNT_W;

   // Configuration registers.
   logic [RW-1:0] on_delta_ff, on_thr_ff, on_cap_ff, clear_thr_ff;
   logic [RW-1:0] off_thr_ff, off_cap_ff, base_min_ff, base_max_ff;

   // Control and statistics state.
   gtcd_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]  fill_ff;
   logic [IDX_W-1:0]  wpos_ff;
   logic [STR_W-1:0]  stride_ff;
   logic              calibrated_ff;
   logic [31:0]       base_ratio_ff, p95_base_ff;
   logic [RW-1:0]     onset_ff, recov_ff;
   gtcd_pkg::path_type path_ff;
   logic [31:0]       median_ff, tail_ff, ratio_ff, excess_ff;
   logic              updated_ff;

   // Radix select state: one bit position per sweep over the window.
   logic [CNT_W-1:0]  sel_cnt_ff;
   logic              rd_vld_ff;
   logic [4:0]        sel_bit_ff;
   logic [31:0]       pre50_ff, pre95_ff;
   logic [IDX_W-1:0]  rem50_ff, rem95_ff;
   logic [CNT_W-1:0]  cnt50_ff, cnt95_ff;

   // Shared restoring divider.
   logic [DW-1:0]     div_q_ff;
   logic [31:0]       div_rem_ff, div_den_ff;
   logic [DCW-1:0]    div_cnt_ff;

   // Output register.
   logic              rsp_valid_ff;
   logic [175:0]      rsp_data_ff;
   logic [2:0]        rsp_user_ff;

   // RAM connections.
   logic              ram_we;
   logic [IDX_W-1:0]  ram_raddr;
   logic [31:0]       ram_rdata;

   logic req_fire, gap_nz, sel_issue, sel_last, div_busy, out_free;
   logic [CNT_W-1:0] fill_next;
   logic [STR_W-1:0] stride_next;
   logic             fill_full, run_now;

   assign req_fire = req_tvalid && req_tready;
   assign gap_nz   = (req_tdata != 32'd0);
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      fill_next   = (fill_ff == CNT_W'(WINDOW_DEPTH)) ? fill_ff : fill_ff + 1'b1;
      fill_full   = (fill_next == CNT_W'(WINDOW_DEPTH));
      stride_next = stride_ff + 1'b1;
      run_now     = fill_full && (!calibrated_ff || stride_next >= STR_W'(UPDATE_STRIDE));
   end

   gtcd_ram #(
      .WIDTH (32),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wpos_ff),
      .wr_data (req_tdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Select sweep control: a read is issued while addresses remain, data follows in the next cycle.
   assign sel_issue = (sel_cnt_ff < CNT_W'(WINDOW_DEPTH));
   assign sel_last  = !sel_issue && !rd_vld_ff;
   assign ram_raddr = sel_cnt_ff[IDX_W-1:0];

   // Prefix compare and bit decisions of the select.
   logic [31:0] hi_mask, nxt50, nxt95;
   logic        hit50, hit95, one50, one95;
   logic [IDX_W-1:0] nrem50, nrem95;
   always_comb begin
      hi_mask = ~(32'hFFFF_FFFF >> (5'd31 - sel_bit_ff));
      hit50   = ((ram_rdata & hi_mask) == (pre50_ff & hi_mask)) && !ram_rdata[sel_bit_ff];
      hit95   = ((ram_rdata & hi_mask) == (pre95_ff & hi_mask)) && !ram_rdata[sel_bit_ff];
      one50   = !(CNT_W'(rem50_ff) < cnt50_ff);
      one95   = !(CNT_W'(rem95_ff) < cnt95_ff);
      nxt50   = pre50_ff;
      nxt95   = pre95_ff;
      nxt50[sel_bit_ff] = one50;
      nxt95[sel_bit_ff] = one95;
      nrem50  = one50 ? IDX_W'(rem50_ff - cnt50_ff) : rem50_ff;
      nrem95  = one95 ? IDX_W'(rem95_ff - cnt95_ff) : rem95_ff;
   end

   // Divider step.
   logic [32:0] div_sh;
   logic        div_ge;
   logic [31:0] div_rem_step;
   always_comb begin
      div_sh       = {div_rem_ff, div_q_ff[DW-1]};
      div_ge       = (div_sh >= {1'b0, div_den_ff});
      div_rem_step = div_ge ? 32'(div_sh - {1'b0, div_den_ff}) : div_sh[31:0];
   end
   assign div_busy = (div_cnt_ff != '0);

   // Divider results, saturated.
   logic [31:0] ratio_res, excess_res, base_clip;
   always_comb begin
      if (median_ff == 32'd0)          ratio_res = 32'd0;
      else if (div_q_ff[DW-1:32] != 0) ratio_res = 32'hFFFF_FFFF;
      else                             ratio_res = div_q_ff[31:0];
      if (base_ratio_ff == 32'd0)              excess_res = 32'd0;
      else if (div_q_ff > DW'(48'h0000_8000_FFFF)) excess_res = 32'h7FFF_FFFF;
      else                                     excess_res = 32'(div_q_ff - DW'(gtcd_pkg::Q_ONE));
      if (ratio_res < {11'd0, base_min_ff})      base_clip = {11'd0, base_min_ff};
      else if (ratio_res > {11'd0, base_max_ff}) base_clip = {11'd0, base_max_ff};
      else                                       base_clip = ratio_res;
   end

   // Tail guard and CUSUM updates.
   logic [32:0]        g_dbl, g_abs, g_lim;
   logic               guard;
   logic signed [33:0] ex_s, ex_clip, ev_on, clr_diff;
   logic signed [34:0] on_acc;
   logic [RW-1:0]      on_new, ev_off, rec_new;
   logic [RW:0]        rec_acc;
   logic               clr_ok;
   always_comb begin
      g_dbl   = {p95_base_ff, 1'b0};
      g_abs   = {1'b0, p95_base_ff} + {1'b0, gtcd_pkg::ABS_GUARD_US};
      g_lim   = (g_dbl < g_abs) ? g_abs : g_dbl;
      guard   = (p95_base_ff != 32'd0) && ({1'b0, tail_ff} >= g_lim);

      ex_s    = 34'(signed'(excess_ff));
      if (ex_s < -34'sd65536)                         ex_clip = -34'sd65536;
      else if (ex_s > signed'({13'd0, on_cap_ff}))    ex_clip = signed'({13'd0, on_cap_ff});
      else                                            ex_clip = ex_s;
      ev_on   = (guard ? ex_clip : 34'sd0) - signed'({13'd0, on_delta_ff});
      on_acc  = signed'({14'd0, onset_ff}) + 35'(ev_on);
      if (on_acc < 35'sd0)                            on_new = '0;
      else if (on_acc > signed'({14'd0, on_thr_ff}))  on_new = on_thr_ff;
      else                                            on_new = on_acc[RW-1:0];

      clr_diff = signed'({13'd0, clear_thr_ff}) - ex_s;
      clr_ok   = !guard && (ex_s <= signed'({13'd0, clear_thr_ff}));
      if (!clr_ok)                                    ev_off = '0;
      else if (clr_diff > signed'({13'd0, off_cap_ff})) ev_off = off_cap_ff;
      else                                            ev_off = clr_diff[RW-1:0];
      rec_acc = {1'b0, recov_ff} + {1'b0, ev_off};
      rec_new = (rec_acc > {1'b0, off_thr_ff}) ? off_thr_ff : rec_acc[RW-1:0];
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gtcd_pkg::S_IDLE: begin
            if (req_fire) begin
               state_in = (gap_nz && run_now) ? gtcd_pkg::S_SELECT : gtcd_pkg::S_DONE;
            end
         end
         gtcd_pkg::S_SELECT: begin
            if (sel_last && sel_bit_ff == 5'd0) state_in = gtcd_pkg::S_DIV_RATIO;
         end
         gtcd_pkg::S_DIV_RATIO: begin
            if (!div_busy) begin
               state_in = calibrated_ff ? gtcd_pkg::S_DIV_EXCESS : gtcd_pkg::S_DONE;
            end
         end
         gtcd_pkg::S_DIV_EXCESS: begin
            if (!div_busy) state_in = gtcd_pkg::S_UPDATE;
         end
         gtcd_pkg::S_UPDATE: state_in = gtcd_pkg::S_DONE;
         gtcd_pkg::S_DONE: begin
            if (out_free) state_in = gtcd_pkg::S_IDLE;
         end
         default: state_in = gtcd_pkg::S_IDLE;
      endcase
   end

   // Output decode of the sequencer.
   always_comb begin
      req_tready = (state_ff == gtcd_pkg::S_IDLE);
      ram_we     = (state_ff == gtcd_pkg::S_IDLE) && req_tvalid && gap_nz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gtcd_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         on_delta_ff  <= gtcd_pkg::RST_ON_DELTA;
         on_thr_ff    <= gtcd_pkg::RST_ON_THR;
         on_cap_ff    <= gtcd_pkg::RST_ON_CAP;
         clear_thr_ff <= gtcd_pkg::RST_CLEAR_THR;
         off_thr_ff   <= gtcd_pkg::RST_OFF_THR;
         off_cap_ff   <= gtcd_pkg::RST_OFF_CAP;
         base_min_ff  <= gtcd_pkg::RST_BASE_MIN;
         base_max_ff  <= gtcd_pkg::RST_BASE_MAX;
      end else if (csr_wr_en) begin
         unique case (gtcd_pkg::csr_index_type'(csr_index))
            gtcd_pkg::REG_ON_DELTA:  on_delta_ff  <= csr_wdata;
            gtcd_pkg::REG_ON_THR:    on_thr_ff    <= csr_wdata;
            gtcd_pkg::REG_ON_CAP:    on_cap_ff    <= csr_wdata;
            gtcd_pkg::REG_CLEAR_THR: clear_thr_ff <= csr_wdata;
            gtcd_pkg::REG_OFF_THR:   off_thr_ff   <= csr_wdata;
            gtcd_pkg::REG_OFF_CAP:   off_cap_ff   <= csr_wdata;
            gtcd_pkg::REG_BASE_MIN:  base_min_ff  <= csr_wdata;
            gtcd_pkg::REG_BASE_MAX:  base_max_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Statistics and control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         wpos_ff       <= '0;
         stride_ff     <= '0;
         calibrated_ff <= 1'b0;
         base_ratio_ff <= '0;
         p95_base_ff   <= '0;
         onset_ff      <= '0;
         recov_ff      <= '0;
         path_ff       <= gtcd_pkg::PATH_UNKNOWN;
         median_ff     <= '0;
         tail_ff       <= '0;
         ratio_ff      <= '0;
         excess_ff     <= '0;
         updated_ff    <= 1'b0;
         rd_vld_ff     <= 1'b0;
         sel_cnt_ff    <= '0;
         div_cnt_ff    <= '0;
      end else begin
         // Read data of an issued select address is valid in the next cycle.
         rd_vld_ff <= (state_ff == gtcd_pkg::S_SELECT) && sel_issue;
         unique case (state_ff)
            gtcd_pkg::S_IDLE: begin
               if (req_fire) begin
                  updated_ff <= gap_nz && run_now;
                  if (gap_nz) begin
                     wpos_ff <= (wpos_ff == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : wpos_ff + 1'b1;
                     fill_ff <= fill_next;
                     if (!fill_full) begin
                        path_ff <= gtcd_pkg::PATH_UNKNOWN;
                     end else if (run_now) begin
                        stride_ff  <= '0;
                        sel_cnt_ff <= '0;
                        sel_bit_ff <= 5'd31;
                        pre50_ff   <= '0;
                        pre95_ff   <= '0;
                        rem50_ff   <= IDX_W'(RANK50);
                        rem95_ff   <= IDX_W'(RANK95);
                        cnt50_ff   <= '0;
                        cnt95_ff   <= '0;
                     end else begin
                        stride_ff <= stride_next;
                     end
                  end
               end
            end
            gtcd_pkg::S_SELECT: begin
               if (sel_issue) begin
                  sel_cnt_ff <= sel_cnt_ff + 1'b1;
               end
               if (rd_vld_ff) begin
                  cnt50_ff <= cnt50_ff + CNT_W'(hit50);
                  cnt95_ff <= cnt95_ff + CNT_W'(hit95);
               end
               if (sel_last) begin
                  pre50_ff   <= nxt50;
                  pre95_ff   <= nxt95;
                  rem50_ff   <= nrem50;
                  rem95_ff   <= nrem95;
                  cnt50_ff   <= '0;
                  cnt95_ff   <= '0;
                  sel_cnt_ff <= '0;
                  sel_bit_ff <= sel_bit_ff - 1'b1;
                  if (sel_bit_ff == 5'd0) begin
                     // Both ranks are settled: start tail*65536 / median.
                     median_ff  <= nxt50;
                     tail_ff    <= nxt95;
                     div_q_ff   <= {nxt95, 16'd0};
                     div_rem_ff <= '0;
                     div_den_ff <= nxt50;
                     div_cnt_ff <= DCW'(DW);
                  end
               end
            end
            gtcd_pkg::S_DIV_RATIO, gtcd_pkg::S_DIV_EXCESS: begin
               if (div_busy) begin
                  div_q_ff   <= {div_q_ff[DW-2:0], div_ge};
                  div_rem_ff <= div_rem_step;
                  div_cnt_ff <= div_cnt_ff - 1'b1;
               end else if (state_ff == gtcd_pkg::S_DIV_RATIO) begin
                  ratio_ff <= ratio_res;
                  if (!calibrated_ff) begin
                     calibrated_ff <= 1'b1;
                     base_ratio_ff <= base_clip;
                     p95_base_ff   <= tail_ff;
                     excess_ff     <= '0;
                     onset_ff      <= '0;
                     recov_ff      <= '0;
                     path_ff       <= gtcd_pkg::PATH_REGULAR;
                  end else begin
                     // Next: ratio*65536 / baseline.
                     div_q_ff   <= {ratio_res, 16'd0};
                     div_rem_ff <= '0;
                     div_den_ff <= base_ratio_ff;
                     div_cnt_ff <= DCW'(DW);
                  end
               end else begin
                  excess_ff <= excess_res;
               end
            end
            gtcd_pkg::S_UPDATE: begin
               if (path_ff != gtcd_pkg::PATH_DEGRADED) begin
                  onset_ff <= on_new;
                  recov_ff <= '0;
                  path_ff  <= (on_new >= on_thr_ff) ? gtcd_pkg::PATH_DEGRADED
                                                    : gtcd_pkg::PATH_REGULAR;
               end else begin
                  recov_ff <= rec_new;
                  onset_ff <= '0;
                  if (rec_new >= off_thr_ff) path_ff <= gtcd_pkg::PATH_REGULAR;
               end
            end
            gtcd_pkg::S_DONE: ;
            default: ;
         endcase
      end
   end

   // Output register: loaded at the end of an item, held until the receiver takes it.
   logic rsp_load;
   assign rsp_load = (state_ff == gtcd_pkg::S_DONE) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {6'd0, recov_ff, onset_ff, excess_ff, ratio_ff, tail_ff, median_ff};
         rsp_user_ff <= {updated_ff, path_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

FILE: tb/tb_gap_tail_cusum_detector.sv
// Self-checking testbench of the gap tail CUSUM detector: stream stimulus, predictor and checker.
module tb_gap_tail_cusum_detector;
   timeunit 1ns;
   timeprecision 1ps;

   import gtcd_pkg::*;

   // The run is aborted if it ever gets this far. A recompute happens at most once per 32
   // nonzero gaps, so a correct run needs far less.
   localparam int CYCLE_LIMIT = 3000000;
   localparam int WIN         = DEF_WINDOW_DEPTH;
   localparam int STRIDE      = DEF_UPDATE_STRIDE;
   localparam int Q16         = 65536;

   // Gap profiles used by the random part.
   typedef enum int {
      GAPS_QUIET,
      GAPS_BURSTY,
      GAPS_SKEWED
   } gap_profile_type;

   // One result transfer, as it is expected on the rsp_ channel.
   typedef struct {
      path_type    path;
      bit          updated;
      bit [31:0]   median;
      bit [31:0]   tail;
      bit [31:0]   ratio;
      bit [31:0]   excess;
      bit [20:0]   on_sum;
      bit [20:0]   off_sum;
   } gap_report_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [31:0]   req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [175:0]  rsp_tdata;
   logic [2:0]    rsp_tuser;
   logic          csr_wr_en = 1'b0;
   logic [IDX_REG_W-1:0] csr_index = '0;
   logic [REG_W-1:0]     csr_wdata = '0;

   gap_tail_cusum_detector uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Shared control between the stimulus, the receiver and the checker.
   int  error_count = 0;
   int  cycle_count = 0;
   bit  sender_idles = 1'b1;     // random gaps between transfers on the req_ side
   bit  receiver_idles = 1'b1;   // random stalls on the rsp_ side
   int  receiver_hold = 0;       // one long stall requested by a test
   bit  offering = 1'b0;         // req_tvalid was left high after the last transfer

   gap_report_type pending_reports[$];

   // ---------------------------------------------------------------------------------
   // Predictor state: its own copy of the registers, the window and the detector state.
   // ---------------------------------------------------------------------------------
   bit [REG_W-1:0] csr_shadow [8];
   bit [31:0]  window_copy [WIN];
   int         fill_level;
   int         write_slot;
   int         stride_level;
   bit         have_baseline;
   bit [31:0]  base_ratio;
   bit [31:0]  base_tail;
   longint     onset_acc;
   longint     recovery_acc;
   path_type   path_now;
   bit [31:0]  median_now;
   bit [31:0]  tail_now;
   bit [31:0]  ratio_now;
   bit [31:0]  excess_now;

   function automatic longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void clear_predictor();
      csr_shadow[REG_ON_DELTA]  = RST_ON_DELTA;
      csr_shadow[REG_ON_THR]    = RST_ON_THR;
      csr_shadow[REG_ON_CAP]    = RST_ON_CAP;
      csr_shadow[REG_CLEAR_THR] = RST_CLEAR_THR;
      csr_shadow[REG_OFF_THR]   = RST_OFF_THR;
      csr_shadow[REG_OFF_CAP]   = RST_OFF_CAP;
      csr_shadow[REG_BASE_MIN]  = RST_BASE_MIN;
      csr_shadow[REG_BASE_MAX]  = RST_BASE_MAX;
      fill_level    = 0;
      write_slot    = 0;
      stride_level  = 0;
      have_baseline = 1'b0;
      base_ratio    = '0;
      base_tail     = '0;
      onset_acc     = 0;
      recovery_acc  = 0;
      path_now      = PATH_UNKNOWN;
      median_now    = '0;
      tail_now      = '0;
      ratio_now     = '0;
      excess_now    = '0;
   endfunction

   // Quantiles over the sorted window, the ratio, and the two CUSUM updates.
   function automatic void recompute_stats();
      bit [31:0]       ordered[$];
      bit [31:0]       p50;
      bit [31:0]       p95;
      longint unsigned quotient;
      longint          excess;
      longint          evidence;
      longint unsigned guard_level;
      bit              tail_high;
      int              i50;
      int              i95;

      foreach (window_copy[k]) ordered.push_back(window_copy[k]);
      ordered.sort();
      i50 = (50 * (WIN - 1) + 99) / 100;
      i95 = (95 * (WIN - 1) + 99) / 100;
      p50 = ordered[i50];
      p95 = ordered[i95];
      if (p50 != 0) begin
         quotient = ({32'd0, p95} << 16) / {32'd0, p50};
         if (quotient > 64'hFFFF_FFFF) quotient = 64'hFFFF_FFFF;
      end else begin
         quotient = 0;
      end
      median_now = p50;
      tail_now   = p95;
      ratio_now  = quotient[31:0];

      // The first full window only sets the baseline and enters the regular state.
      if (!have_baseline) begin
         have_baseline = 1'b1;
         base_ratio    = 32'(clamp(longint'(quotient), longint'(csr_shadow[REG_BASE_MIN]),
                                   longint'(csr_shadow[REG_BASE_MAX])));
         base_tail     = p95;
         excess_now    = '0;
         onset_acc     = 0;
         recovery_acc  = 0;
         path_now      = PATH_REGULAR;
         return;
      end

      excess = 0;
      if (base_ratio != 0) begin
         quotient = ({32'd0, ratio_now} << 16) / {32'd0, base_ratio};
         excess = clamp(longint'(quotient) - Q16, -64'sd2147483648, 64'sd2147483647);
      end
      excess_now = excess[31:0];

      // The tail must also have grown in absolute terms before onset evidence counts.
      tail_high = 1'b0;
      if (base_tail != 0) begin
         guard_level = 64'(base_tail) * 2;
         if (guard_level < 64'(base_tail) + 64'(ABS_GUARD_US))
            guard_level = 64'(base_tail) + 64'(ABS_GUARD_US);
         tail_high = 64'(tail_now) >= guard_level;
      end

      if (path_now != PATH_DEGRADED) begin
         if (tail_high)
            evidence = clamp(excess, -Q16, longint'(csr_shadow[REG_ON_CAP]))
                       - longint'(csr_shadow[REG_ON_DELTA]);
         else
            evidence = -longint'(csr_shadow[REG_ON_DELTA]);
         onset_acc = clamp(onset_acc + evidence, 0, longint'(csr_shadow[REG_ON_THR]));
         recovery_acc = 0;
         path_now = (onset_acc >= longint'(csr_shadow[REG_ON_THR])) ? PATH_DEGRADED
                                                                      : PATH_REGULAR;
         return;
      end

      if (!tail_high && excess <= longint'(csr_shadow[REG_CLEAR_THR]))
         evidence = clamp(longint'(csr_shadow[REG_CLEAR_THR]) - excess, 0,
                          longint'(csr_shadow[REG_OFF_CAP]));
      else
         evidence = 0;
      recovery_acc = clamp(recovery_acc + evidence, 0, longint'(csr_shadow[REG_OFF_THR]));
      onset_acc = 0;
      if (recovery_acc >= longint'(csr_shadow[REG_OFF_THR])) path_now = PATH_REGULAR;
   endfunction

   // Advances the predictor by one gap and returns the report it causes.
   function automatic gap_report_type predict_report(bit [31:0] gap);
      gap_report_type rep;
      bit             updated;
      bit             run;

      updated = 1'b0;
      if (gap != 0) begin
         window_copy[write_slot] = gap;
         write_slot = (write_slot + 1) % WIN;
         if (fill_level < WIN) fill_level++;
         if (fill_level < WIN) begin
            path_now = PATH_UNKNOWN;
         end else begin
            run = 1'b1;
            if (have_baseline) begin
               stride_level++;
               if (stride_level < STRIDE) run = 1'b0;
            end
            if (run) begin
               stride_level = 0;
               recompute_stats();
               updated = 1'b1;
            end
         end
      end
      rep.path    = path_now;
      rep.updated = updated;
      rep.median  = median_now;
      rep.tail    = tail_now;
      rep.ratio   = ratio_now;
      rep.excess  = excess_now;
      rep.on_sum  = onset_acc[20:0];
      rep.off_sum = recovery_acc[20:0];
      return rep;
   endfunction

   // ---------------------------------------------------------------------------------
   // Checker: every rsp_ transfer is compared with the oldest pending report.
   // ---------------------------------------------------------------------------------
   function automatic void compare_field(string label, longint unsigned want,
                                         longint unsigned got);
      if (want != got) begin
         $display("%0t: mismatch in %s, expected 0x%0h, actual 0x%0h", $time, label, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      gap_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: result transfer with no report pending, actual tuser 0x%0h",
                     $time, rsp_tuser);
            error_count++;
         end else begin
            want = pending_reports.pop_front();
            compare_field("path_state",    want.path,    rsp_tuser[1:0]);
            compare_field("stats_updated", want.updated, rsp_tuser[2]);
            compare_field("median_gap",    want.median,  rsp_tdata[31:0]);
            compare_field("tail_gap",      want.tail,    rsp_tdata[63:32]);
            compare_field("p95_ratio",     want.ratio,   rsp_tdata[95:64]);
            compare_field("p95_excess",    want.excess,  rsp_tdata[127:96]);
            compare_field("on_sum",        want.on_sum,  rsp_tdata[148:128]);
            compare_field("off_sum",       want.off_sum, rsp_tdata[169:149]);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver: random stall bursts, stretches of steady acceptance, and one long
   // hold-off when a test asks for it, so that the block backs up into req_tready.
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (receiver_hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (receiver_hold) @(posedge clock);
            receiver_hold = 0;
         end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------------------

   // Offers one gap, waits for the transfer, and records the report it must cause.
   task automatic send_gap(bit [31:0] gap);
      req_tvalid <= 1'b1;
      req_tdata  <= gap;
      do @(posedge clock); while (!req_tready);
      pending_reports.push_back(predict_report(gap));
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end else begin
         offering = 1'b1;
      end
   endtask

   // Stops offering and waits until every pending report has arrived. The block
   // always answers, so a short settle afterwards leaves it idle.
   task automatic drain_reports();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Writes all eight registers back to back; the block must be idle.
   task automatic load_registers(bit [REG_W-1:0] vals [8]);
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         csr_shadow[i] = vals[i];
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic bit [31:0] pick_gap(gap_profile_type profile);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) return 32'd0;                       // ignored sample
      if (roll < 8) begin
         case ($urandom_range(0, 2))
            0: return 32'd1;
            1: return 32'hFFFF_FFFF;
            default: return $urandom() | 32'd1;
         endcase
      end
      case (profile)
         GAPS_QUIET:  return $urandom_range(800, 1300);
         GAPS_BURSTY: begin
            if ($urandom_range(0, 99) < 25) return $urandom_range(15000, 80000);
            return $urandom_range(800, 1300);
         end
         default: begin
            // Tiny median against a huge tail drives the ratio into saturation.
            if ($urandom_range(0, 99) < 55) return $urandom_range(1, 3);
            return $urandom() | 32'h8000_0000;
         end
      endcase
   endfunction

   task automatic send_profile(gap_profile_type profile, int count);
      for (int i = 0; i < count; i++) send_gap(pick_gap(profile));
   endtask

   // ---------------------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------------------

   // The baseline is fixed once, at the first full window. Its clip bounds are chosen
   // at random: defaults, crossed bounds, or a zero baseline that keeps the excess 0.
   task automatic test_baseline_setup();
      bit [REG_W-1:0] vals [8];
      vals = '{RST_ON_DELTA, RST_ON_THR, RST_ON_CAP, RST_CLEAR_THR,
               RST_OFF_THR, RST_OFF_CAP, RST_BASE_MIN, RST_BASE_MAX};
      case ($urandom_range(0, 2))
         0: ;
         1: begin
            vals[REG_BASE_MIN] = 21'd98304;   // 1.5, above the maximum
            vals[REG_BASE_MAX] = 21'd65536;   // 1.0
         end
         default: begin
            vals[REG_BASE_MIN] = '0;
            vals[REG_BASE_MAX] = '0;
         end
      endcase
      load_registers(vals);
   endtask

   // Field extremes, single bits and ignored samples while the window fills.
   task automatic test_directed_gaps();
      bit [31:0] gaps [$];
      gaps = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF,
               32'hAAAA_AAAA, 32'h5555_5555, 32'd0};
      foreach (gaps[i]) send_gap(gaps[i]);
      for (int i = 0; i < 16; i++) send_gap($urandom_range(900, 1100));
   endtask

   // Completes the window, which calibrates, and then feeds further quiet gaps.
   task automatic test_calibration();
      send_profile(GAPS_QUIET, 150);
      drain_reports();
   endtask

   // Tail bursts push the onset CUSUM up. The receiver holds off for a long time
   // at the start so that the block fills up and stalls its input.
   task automatic test_onset();
      bit [REG_W-1:0] vals [8];
      vals = '{RST_ON_DELTA, RST_ON_THR, RST_ON_CAP, RST_CLEAR_THR,
               RST_OFF_THR, RST_OFF_CAP, RST_BASE_MIN, RST_BASE_MAX};
      load_registers(vals);
      receiver_hold = 600;
      send_profile(GAPS_BURSTY, 200);
      drain_reports();
   endtask

   // Quiet traffic lets the recovery CUSUM build up, with random register values.
   // Halfway through, the sender pauses until every report has come back.
   task automatic test_recovery();
      bit [REG_W-1:0] vals [8];
      foreach (vals[i]) vals[i] = REG_W'($urandom_range(0, 262144));
      load_registers(vals);
      send_profile(GAPS_QUIET, 100);
      drain_reports();
      send_profile(GAPS_QUIET, 100);
      drain_reports();
   endtask

   // With all thresholds at zero the state flips on every update.
   task automatic test_zero_thresholds();
      bit [REG_W-1:0] vals [8];
      vals = '{default: '0};
      load_registers(vals);
      send_profile(GAPS_BURSTY, 80);
      send_profile(GAPS_QUIET, 60);
      drain_reports();
   endtask

   // Register values of 1048576, half the 21-bit range, with a skewed window that saturates ratio and excess.
   task automatic test_saturation();
      bit [REG_W-1:0] vals [8];
      vals = '{default: 21'd1048576};
      load_registers(vals);
      send_profile(GAPS_SKEWED, 60);
      drain_reports();
   endtask

   // Back-to-back transfers with no idling on either side.
   task automatic test_full_rate();
      bit [REG_W-1:0] vals [8];
      vals = '{21'd16384, 21'd65536, 21'd131072, 21'd65536,
               21'd65536, 21'd65536, 21'd78643, 21'd163840};
      load_registers(vals);
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      send_profile(GAPS_BURSTY, 100);
   endtask

   initial begin
      clear_predictor();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_baseline_setup();
      test_directed_gaps();
      test_calibration();
      test_onset();
      test_recovery();
      test_zero_thresholds();
      test_saturation();
      test_full_rate();

      drain_reports();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
